// ===== design/sspg_pkg.sv =====
// Shared types, constants and tables for the status screen pixel generator.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package sspg_pkg;

  // Frame geometry.
  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 96;

  // Screen mode codes; the last value has no screen and yields zero beats.
  localparam logic [1:0] MODE_LOADING   = 2'd0;
  localparam logic [1:0] MODE_NO_SENSOR = 2'd1;
  localparam logic [1:0] MODE_RANGE_ERR = 2'd2;
  localparam logic [1:0] MODE_NONE      = 2'd3;

  // Text placement.
  localparam int TEXT_TOP    = 41;
  localparam int TEXT_BOTTOM = TEXT_TOP + 13;
  localparam int CELL_PITCH  = 12;
  localparam int LEN_LOADING = 7;
  localparam int LEN_LONG    = 9;
  localparam int TW_LOADING  = LEN_LOADING * CELL_PITCH - 2;
  localparam int TW_LONG     = LEN_LONG * CELL_PITCH - 2;
  localparam int X0_LOADING  = (FRAME_WIDTH >= TW_LOADING) ? (FRAME_WIDTH - TW_LOADING) / 2 : 0;
  localparam int X0_LONG     = (FRAME_WIDTH >= TW_LONG) ? (FRAME_WIDTH - TW_LONG) / 2 : 0;

  // Reciprocal of the cell pitch, scaled by 2^11; exact for offsets below 128.
  localparam int RECIP_SHIFT = 11;
  localparam logic [14:0] RECIP_PITCH = 15'd171;

  // Glyph indices.
  localparam logic [3:0] G_A = 4'd0;
  localparam logic [3:0] G_D = 4'd1;
  localparam logic [3:0] G_E = 4'd2;
  localparam logic [3:0] G_F = 4'd3;
  localparam logic [3:0] G_G = 4'd4;
  localparam logic [3:0] G_I = 4'd5;
  localparam logic [3:0] G_L = 4'd6;
  localparam logic [3:0] G_N = 4'd7;
  localparam logic [3:0] G_O = 4'd8;
  localparam logic [3:0] G_R = 4'd9;
  localparam logic [3:0] G_S = 4'd10;
  localparam logic [3:0] G_T = 4'd11;
  localparam logic [3:0] G_U = 4'd12;
  localparam logic [3:0] G_SLASH = 4'd13;
  localparam logic [3:0] NO_GLYPH = 4'd14;

  typedef struct packed {
    logic [5:0] pair_column;
    logic [6:0] row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } out_item_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] cb;
    logic [7:0] cr;
  } colour_t;

  localparam colour_t WHITE = '{y: 8'd235, cb: 8'd128, cr: 8'd128};
  localparam colour_t BLACK = '{y: 8'd16,  cb: 8'd128, cr: 8'd128};

  function automatic colour_t bar_colour(input logic [2:0] idx);
    colour_t c;
    unique case (idx)
      3'd0: c = WHITE;
      3'd1: c = '{y: 8'd210, cb: 8'd16,  cr: 8'd146};
      3'd2: c = '{y: 8'd169, cb: 8'd166, cr: 8'd16};
      3'd3: c = '{y: 8'd144, cb: 8'd54,  cr: 8'd34};
      3'd4: c = '{y: 8'd107, cb: 8'd202, cr: 8'd222};
      3'd5: c = '{y: 8'd82,  cb: 8'd90,  cr: 8'd240};
      3'd6: c = '{y: 8'd41,  cb: 8'd240, cr: 8'd110};
      3'd7: c = '{y: 8'd44,  cb: 8'd128, cr: 8'd128};
      default: c = WHITE;
    endcase
    return c;
  endfunction

  // Seven rows of five dots, top row in the most significant bits.
  function automatic logic [34:0] glyph_bits(input logic [3:0] g);
    logic [34:0] b;
    unique case (g)
      G_A:     b = 35'b01110_10001_10001_11111_10001_10001_10001;
      G_D:     b = 35'b11110_10001_10001_10001_10001_10001_11110;
      G_E:     b = 35'b11111_10000_10000_11110_10000_10000_11111;
      G_F:     b = 35'b11111_10000_10000_11110_10000_10000_10000;
      G_G:     b = 35'b01110_10001_10000_10111_10001_10001_01110;
      G_I:     b = 35'b11111_00100_00100_00100_00100_00100_11111;
      G_L:     b = 35'b10000_10000_10000_10000_10000_10000_11111;
      G_N:     b = 35'b10001_11001_10101_10011_10001_10001_10001;
      G_O:     b = 35'b01110_10001_10001_10001_10001_10001_01110;
      G_R:     b = 35'b11110_10001_10001_11110_10100_10010_10001;
      G_S:     b = 35'b01111_10000_10000_01110_00001_00001_11110;
      G_T:     b = 35'b11111_00100_00100_00100_00100_00100_00100;
      G_U:     b = 35'b10001_10001_10001_10001_10001_10001_01110;
      G_SLASH: b = 35'b00001_00010_00010_00100_01000_01000_10000;
      default: b = '0;
    endcase
    return b;
  endfunction

  // Character of each text line; positions past the end are blank.
  function automatic logic [3:0] line_glyph(input logic [1:0] mode, input logic [3:0] ci);
    logic [3:0] g;
    g = NO_GLYPH;
    unique case (mode)
      MODE_LOADING: begin
        unique case (ci)
          4'd0: g = G_L;
          4'd1: g = G_O;
          4'd2: g = G_A;
          4'd3: g = G_D;
          4'd4: g = G_I;
          4'd5: g = G_N;
          4'd6: g = G_G;
          default: g = NO_GLYPH;
        endcase
      end
      MODE_NO_SENSOR: begin
        unique case (ci)
          4'd0: g = G_N;
          4'd1: g = G_O;
          4'd3: g = G_S;
          4'd4: g = G_E;
          4'd5: g = G_N;
          4'd6: g = G_S;
          4'd7: g = G_O;
          4'd8: g = G_R;
          default: g = NO_GLYPH;
        endcase
      end
      MODE_RANGE_ERR: begin
        unique case (ci)
          4'd0: g = G_R;
          4'd1: g = G_A;
          4'd2: g = G_N;
          4'd3: g = G_G;
          4'd4: g = G_E;
          4'd5: g = G_SLASH;
          4'd6: g = G_E;
          4'd7: g = G_R;
          4'd8: g = G_R;
          default: g = NO_GLYPH;
        endcase
      end
      default: g = NO_GLYPH;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== design/status_screen_pixel_generator_top.sv =====
// Top level of the status screen pixel generator: input register, pixel logic
// and result register. Depends on sspg_pkg and sspg_pixel.
`default_nettype none

// One pixel pair is accepted per clock while in_ready is high; it is held in
// the input register, its colour is worked out by the pixel logic and its YUYV
// bytes are caught in the result register. in_ready stays high unless both
// registers hold a pair and out_ready is low; then the pipeline holds. The user
// must write screen_mode through cfg_wen/cfg_wdata only while the block is idle;
// the block does not enforce this. Mode 3 and pairs outside the frame yield all-zero beats.
module status_screen_pixel_generator_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic [1:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sspg_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sspg_pkg::out_item_t     out_data
);
  import sspg_pkg::*;

  logic [1:0] screen_mode;
  logic       stage_valid;
  in_item_t   stage_item;
  out_item_t  pixel_result;
  logic       advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_mode <= MODE_LOADING;
    end else if (cfg_wen) begin
      screen_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_data;
    end
    if (advance && stage_valid) begin
      out_data <= pixel_result;
    end
  end

  sspg_pixel u_pixel (
    .mode   (screen_mode),
    .item   (stage_item),
    .result (pixel_result)
  );

endmodule

`default_nettype wire

// ===== design/sspg_dot.sv =====
// Text dot test for one pixel: is it covered by a font dot of the mode's line?
// Depends on sspg_pkg for the font, the text lines and their placement.
`default_nettype none

module sspg_dot (
  input  wire logic [1:0] mode,
  input  wire logic [6:0] px,
  input  wire logic [6:0] row,
  output logic            dot
);
  import sspg_pkg::*;

  logic [9:0]  x0;
  logic [3:0]  len;
  logic        in_rows;
  logic [6:0]  row_off;
  logic [2:0]  font_row;
  logic        left_of_text;
  logic [6:0]  rel;
  logic [14:0] prod;
  logic [3:0]  ci;
  logic [6:0]  cell_off;
  logic [3:0]  g;
  logic [34:0] bits;
  logic [4:0]  row_bits;
  logic [5:0]  row_sel;
  logic [2:0]  col_sel;

  always_comb begin
    if (mode == MODE_LOADING) begin
      x0  = 10'(X0_LOADING);
      len = 4'(LEN_LOADING);
    end else begin
      x0  = 10'(X0_LONG);
      len = 4'(LEN_LONG);
    end
  end

  assign in_rows  = (row >= 7'(TEXT_TOP)) && (row <= 7'(TEXT_BOTTOM));
  assign row_off  = row - 7'(TEXT_TOP);
  assign font_row = row_off[3:1];

  assign left_of_text = {3'b000, px} < x0;
  assign rel          = px - x0[6:0];

  // Cell index and offset within the cell, by reciprocal multiplication.
  assign prod     = 15'(rel) * RECIP_PITCH;
  assign ci       = prod[RECIP_SHIFT +: 4];
  assign cell_off = rel - 7'(ci) * 7'(CELL_PITCH);

  assign g        = line_glyph(mode, ci);
  assign bits     = glyph_bits(g);
  assign row_sel  = 6'(3'd6 - font_row) * 6'd5;
  assign row_bits = bits[row_sel +: 5];
  assign col_sel  = 3'd4 - cell_off[3:1];

  always_comb begin
    dot = 1'b0;
    if (in_rows && !left_of_text && ci < len && cell_off < 7'd10 && g != NO_GLYPH) begin
      dot = row_bits[col_sel];
    end
  end

endmodule

`default_nettype wire

// ===== design/sspg_pixel.sv =====
// Colour of one pixel pair: background for the mode, text overlay, frame bounds.
// Depends on sspg_pkg and on sspg_dot, used once for each pixel of the pair.
`default_nettype none

module sspg_pixel (
  input  wire logic [1:0]         mode,
  input  wire sspg_pkg::in_item_t item,
  output sspg_pkg::out_item_t     result
);
  import sspg_pkg::*;

  logic [6:0] px_even;
  logic [6:0] px_odd;
  logic       dot_even;
  logic       dot_odd;
  logic       outside;
  logic       in_box;
  colour_t    c;

  assign px_even = {item.pair_column, 1'b0};
  assign px_odd  = {item.pair_column, 1'b1};

  sspg_dot u_dot_even (
    .mode (mode),
    .px   (px_even),
    .row  (item.row),
    .dot  (dot_even)
  );

  sspg_dot u_dot_odd (
    .mode (mode),
    .px   (px_odd),
    .row  (item.row),
    .dot  (dot_odd)
  );

  assign outside = (mode == MODE_NONE)
                || ({4'b0000, px_even} >= 11'(FRAME_WIDTH))
                || ({4'b0000, item.row} >= 11'(FRAME_HEIGHT));

  assign in_box = (px_even >= 7'd16) && (px_even <= 7'd111)
               && (item.row >= 7'd35) && (item.row <= 7'd60);

  always_comb begin
    if (mode == MODE_LOADING && !in_box) begin
      c = bar_colour(item.pair_column[5:3]);
    end else begin
      c = WHITE;
    end
    if (dot_even || dot_odd) begin
      c = BLACK;
    end
    if (outside) begin
      result = '0;
    end else begin
      result.luma_first  = c.y;
      result.chroma_blue = c.cb;
      result.luma_second = c.y;
      result.chroma_red  = c.cr;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_status_screen_pixel_generator_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the status screen pixel generator top level.
// Depends on sspg_pkg and status_screen_pixel_generator_top only.

module tb_status_screen_pixel_generator_top;
  import sspg_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 300;

  localparam out_item_t OUT_WHITE  = '{8'd235, 8'd128, 8'd235, 8'd128};
  localparam out_item_t OUT_BLACK  = '{8'd16, 8'd128, 8'd16, 8'd128};
  localparam out_item_t OUT_GREY   = '{8'd44, 8'd128, 8'd44, 8'd128};
  localparam out_item_t OUT_YELLOW = '{8'd210, 8'd16, 8'd210, 8'd146};
  localparam out_item_t OUT_ZERO   = '0;

  typedef struct packed {
    logic [1:0] mode;
    in_item_t   pair;
    logic       typed;
    out_item_t  want;
  } probe_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_wen = 1'b0;
  logic [1:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Travel with in_data so that the monitor sees them alongside the beat.
  logic      row_typed = 1'b0;
  out_item_t row_want = '0;

  out_item_t expected_pixels[$];
  logic [1:0] mode_now = MODE_LOADING;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycles = 0;

  sspg_pkg::colour_t bar_palette [8] = '{
    '{8'd235, 8'd128, 8'd128}, '{8'd210, 8'd16, 8'd146}, '{8'd169, 8'd166, 8'd16},
    '{8'd144, 8'd54, 8'd34}, '{8'd107, 8'd202, 8'd222}, '{8'd82, 8'd90, 8'd240},
    '{8'd41, 8'd240, 8'd110}, '{8'd44, 8'd128, 8'd128}
  };
  sspg_pkg::colour_t pal_white = '{8'd235, 8'd128, 8'd128};
  sspg_pkg::colour_t pal_black = '{8'd16, 8'd128, 8'd128};

  // Rows of each glyph, leftmost dot in bit 4; order A D E F G I L N O R S T U /.
  logic [4:0] glyph_rows [14][7] = '{
    '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14},
    '{5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd31},
    '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
    '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
    '{5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30},
    '{5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd1, 5'd2, 5'd2, 5'd4, 5'd8, 5'd8, 5'd16}
  };

  logic [3:0] text_line [3][9] = '{
    '{G_L, G_O, G_A, G_D, G_I, G_N, G_G, NO_GLYPH, NO_GLYPH},
    '{G_N, G_O, NO_GLYPH, G_S, G_E, G_N, G_S, G_O, G_R},
    '{G_R, G_A, G_N, G_G, G_E, G_SLASH, G_E, G_R, G_R}
  };

  probe_t probes [24] = '{
    '{MODE_LOADING, '{6'd0, 7'd0}, 1'b1, OUT_WHITE},
    '{MODE_LOADING, '{6'd63, 7'd95}, 1'b1, OUT_GREY},
    '{MODE_LOADING, '{6'd63, 7'd0}, 1'b1, OUT_GREY},
    '{MODE_LOADING, '{6'd0, 7'd95}, 1'b1, OUT_WHITE},
    '{MODE_LOADING, '{6'd0, 7'd127}, 1'b1, OUT_ZERO},
    '{MODE_LOADING, '{6'd63, 7'd96}, 1'b1, OUT_ZERO},
    '{MODE_LOADING, '{6'd8, 7'd35}, 1'b1, OUT_WHITE},
    '{MODE_LOADING, '{6'd55, 7'd60}, 1'b1, OUT_WHITE},
    '{MODE_LOADING, '{6'd56, 7'd60}, 1'b1, OUT_GREY},
    '{MODE_LOADING, '{6'd8, 7'd34}, 1'b1, OUT_YELLOW},
    '{MODE_LOADING, '{6'd8, 7'd61}, 1'b1, OUT_YELLOW},
    '{MODE_LOADING, '{6'd11, 7'd41}, 1'b1, OUT_BLACK},
    '{MODE_LOADING, '{6'd20, 7'd47}, 1'b0, OUT_ZERO},
    '{MODE_LOADING, '{6'd42, 7'd54}, 1'b0, OUT_ZERO},
    '{MODE_NO_SENSOR, '{6'd18, 7'd41}, 1'b0, OUT_ZERO},
    '{MODE_NO_SENSOR, '{6'd5, 7'd41}, 1'b0, OUT_ZERO},
    '{MODE_NO_SENSOR, '{6'd63, 7'd55}, 1'b1, OUT_WHITE},
    '{MODE_NO_SENSOR, '{6'd30, 7'd48}, 1'b0, OUT_ZERO},
    '{MODE_RANGE_ERR, '{6'd32, 7'd47}, 1'b0, OUT_ZERO},
    '{MODE_RANGE_ERR, '{6'd5, 7'd40}, 1'b1, OUT_WHITE},
    '{MODE_RANGE_ERR, '{6'd58, 7'd54}, 1'b0, OUT_ZERO},
    '{MODE_NONE, '{6'd0, 7'd0}, 1'b1, OUT_ZERO},
    '{MODE_NONE, '{6'd63, 7'd95}, 1'b1, OUT_ZERO},
    '{MODE_NONE, '{6'd30, 7'd45}, 1'b1, OUT_ZERO}
  };

  status_screen_pixel_generator_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  function automatic bit dot_lit(input logic [1:0] mode, input int px, input int r);
    int n, x0, rel, ci, cell_off;
    logic [3:0] g;
    n = (mode == MODE_LOADING) ? LEN_LOADING : LEN_LONG;
    x0 = (FRAME_WIDTH - (n * CELL_PITCH - 2)) / 2;
    if (r < TEXT_TOP || r > TEXT_TOP + 13 || px < x0) return 1'b0;
    rel = px - x0;
    ci = rel / CELL_PITCH;
    cell_off = rel % CELL_PITCH;
    if (ci >= n || cell_off >= 10) return 1'b0;
    g = text_line[mode][ci];
    if (g == NO_GLYPH) return 1'b0;
    return glyph_rows[g][(r - TEXT_TOP) / 2][4 - cell_off / 2];
  endfunction

  function automatic out_item_t screen_pixel(input logic [1:0] mode, input in_item_t pair);
    int px, r;
    sspg_pkg::colour_t c;
    out_item_t o;
    px = int'(pair.pair_column) * 2;
    r = int'(pair.row);
    o = '0;
    if (mode == MODE_NONE || px >= FRAME_WIDTH || r >= FRAME_HEIGHT) return o;
    if (mode == MODE_LOADING) begin
      c = bar_palette[pair.pair_column[5:3]];
      if (px >= 16 && px <= 111 && r >= 35 && r <= 60) c = pal_white;
    end else begin
      c = pal_white;
    end
    // A dot starting on an odd column darkens both pairs it touches.
    if (dot_lit(mode, px, r) || dot_lit(mode, px + 1, r)) c = pal_black;
    o.luma_first = c.y;
    o.chroma_blue = c.cb;
    o.luma_second = c.y;
    o.chroma_red = c.cr;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_pair(input in_item_t pair, input logic typed, input out_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pair;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lowers valid and waits until every beat in flight has come out.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic set_mode(input logic [1:0] mode);
    drain_pixels();
    cfg_wen <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_wen <= 1'b0;
    mode_now = mode;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver keeps its own count for a long hold-off.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_pixels.push_back(row_typed ? row_want : screen_pixel(mode_now, in_data));
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got %h", $time, out_data);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("luma_first", want.luma_first, out_data.luma_first);
          check_field("chroma_blue", want.chroma_blue, out_data.chroma_blue);
          check_field("luma_second", want.luma_second, out_data.luma_second);
          check_field("chroma_red", want.chroma_red, out_data.chroma_red);
        end
      end
    end
  end

  initial begin
    in_item_t pick;
    int sel, count;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 80;

    foreach (probes[i]) begin
      if (probes[i].mode != mode_now) set_mode(probes[i].mode);
      send_pair(probes[i].pair, probes[i].typed, probes[i].want);
    end

    // Three idling regimes, each going through every screen mode.
    for (int regime = 0; regime < 3; regime++) begin
      send_idle_pct = (regime == 0) ? 37 : (regime == 1) ? 80 : 0;
      recv_idle_pct = (regime == 0) ? 80 : (regime == 1) ? 37 : 0;
      for (int m = 0; m < 4; m++) begin
        set_mode(m[1:0]);
        if (regime == 2 && m == 0) hold_req = LONG_HOLD;
        count = (m == MODE_NONE) ? 40 : 170;
        for (int k = 0; k < count; k++) begin
          if (k == count / 2) drain_pixels();
          sel = $urandom_range(99);
          pick.pair_column = 6'($urandom_range(63));
          if (sel < 50) pick.row = 7'($urandom_range(TEXT_TOP + 13, TEXT_TOP));
          else if (sel < 65) pick.row = 7'($urandom_range(60, 35));
          else if (sel < 90) pick.row = 7'($urandom_range(FRAME_HEIGHT - 1, 0));
          else pick.row = 7'($urandom_range(127, FRAME_HEIGHT));
          send_pair(pick, 1'b0, OUT_ZERO);
        end
      end
    end

    drain_pixels();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
